### rtl/sne_pkg.sv
package sne_pkg;

  localparam int unsigned NameLen = 11;
  localparam int unsigned BaseMax = 8;
  localparam int unsigned ExtMax  = 3;

  localparam logic [3:0] LastPos = 4'(NameLen - 1);
  localparam logic [3:0] BaseLim = 4'(BaseMax);
  localparam logic [1:0] ExtLim  = 2'(ExtMax);

  localparam logic [7:0] PadByte = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7a;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] CaseGap = 8'h20;

  typedef struct packed {
    logic [7:0] character;
    logic       name_end;
  } char_item_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic [3:0] byte_position;
    logic       name_ok;
    logic       last_byte;
  } name_byte_t;

  typedef struct packed {
    logic [7:0] folded;
    logic       is_valid;
    logic       is_dot;
  } char_class_t;

endpackage

### rtl/sne_char_class.sv
module sne_char_class (
  input  logic [7:0]          character,
  output sne_pkg::char_class_t cls
);
  import sne_pkg::*;

  logic [7:0] up;
  logic       punct;

  always_comb begin
    if (character >= ChLowA && character <= ChLowZ) begin
      up = character - CaseGap;
    end else begin
      up = character;
    end
  end

  always_comb begin
    unique case (up)
      8'h24, 8'h25, 8'h27, 8'h2d, 8'h5f, 8'h40, 8'h7e, 8'h60,
      8'h21, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5e, 8'h23, 8'h26: begin
        punct = 1'b1;
      end
      default: begin
        punct = 1'b0;
      end
    endcase
  end

  assign cls.folded   = up;
  assign cls.is_dot   = (character == ChDot);
  assign cls.is_valid = (up >= ChUpA && up <= ChUpZ) || (up >= Ch0 && up <= Ch9) || punct;

endmodule

### rtl/short_name_encoder_core.sv
// 8.3 short name encoder.
// Request channel (char_valid/char_ready/char_req): one name byte per request,
// or an end marker (name_end=1) that closes the name.
// Result channel (byte_valid/byte_ready/byte_rsp): eleven results per end
// marker, positions 0..10, space padded, name_ok repeated on all, last_byte
// on position 10.
// Character requests are taken one per cycle and update the name state in
// the cycle they are accepted; they produce no result.
// An end marker copies the name into an output buffer and clears the state.
// The first result is valid the cycle after the end marker is accepted and
// the buffer then drains one result per cycle that byte_ready is high.
// Characters of the next name are still taken while the buffer drains; an
// end marker waits only until the last result of the previous name leaves.
// A stalled receiver holds the current result and, through the buffer, only
// the next end marker.
// Reset (synchronous) empties the buffer and clears the name state.
module short_name_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_ready,
  input  sne_pkg::char_item_t char_req,
  output logic                byte_valid,
  input  logic                byte_ready,
  output sne_pkg::name_byte_t byte_rsp
);
  import sne_pkg::*;

  logic [7:0] enc [NameLen];
  logic [7:0] enc_next [NameLen];
  logic [3:0] base_count, base_count_next;
  logic [1:0] ext_count, ext_count_next;
  logic       dot_seen, dot_seen_next;
  logic       error_seen, error_seen_next;

  logic [7:0] snap [NameLen];
  logic [3:0] pos;
  logic       snap_ok;

  char_class_t cls;
  logic        out_take, done_take, buf_free, in_take, end_take, chr_take;
  logic        wr_en;
  logic [3:0]  wr_idx;
  logic        name_ok;

  sne_char_class u_class (
    .character (char_req.character),
    .cls       (cls)
  );

  assign out_take  = byte_valid && byte_ready;
  assign done_take = out_take && (pos == LastPos);
  assign buf_free  = !byte_valid || done_take;
  assign char_ready = buf_free || !char_req.name_end;
  assign in_take   = char_valid && char_ready;
  assign end_take  = in_take && char_req.name_end;
  assign chr_take  = in_take && !char_req.name_end;

  assign name_ok = !error_seen && (base_count != 4'd0) && (!dot_seen || ext_count != 2'd0);
  assign wr_idx  = dot_seen ? (BaseLim + 4'(ext_count)) : base_count;

  always_comb begin
    base_count_next = base_count;
    ext_count_next  = ext_count;
    dot_seen_next   = dot_seen;
    error_seen_next = error_seen;
    wr_en           = 1'b0;
    if (end_take) begin
      base_count_next = '0;
      ext_count_next  = '0;
      dot_seen_next   = 1'b0;
      error_seen_next = 1'b0;
    end else if (chr_take && !error_seen) begin
      if (cls.is_dot) begin
        if (dot_seen || base_count == 4'd0) begin
          error_seen_next = 1'b1;
        end else begin
          dot_seen_next = 1'b1;
        end
      end else if (!cls.is_valid) begin
        error_seen_next = 1'b1;
      end else if (!dot_seen) begin
        if (base_count >= BaseLim) begin
          error_seen_next = 1'b1;
        end else begin
          wr_en           = 1'b1;
          base_count_next = base_count + 4'd1;
        end
      end else begin
        if (ext_count >= ExtLim) begin
          error_seen_next = 1'b1;
        end else begin
          wr_en          = 1'b1;
          ext_count_next = ext_count + 2'd1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NameLen; k++) begin
      if (end_take) begin
        enc_next[k] = PadByte;
      end else if (wr_en && wr_idx == 4'(k)) begin
        enc_next[k] = cls.folded;
      end else begin
        enc_next[k] = enc[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_count <= '0;
      ext_count  <= '0;
      dot_seen   <= 1'b0;
      error_seen <= 1'b0;
      for (int k = 0; k < NameLen; k++) begin
        enc[k] <= PadByte;
      end
    end else begin
      base_count <= base_count_next;
      ext_count  <= ext_count_next;
      dot_seen   <= dot_seen_next;
      error_seen <= error_seen_next;
      enc        <= enc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      pos        <= '0;
    end else if (end_take) begin
      byte_valid <= 1'b1;
      pos        <= '0;
    end else if (done_take) begin
      byte_valid <= 1'b0;
      pos        <= '0;
    end else if (out_take) begin
      pos <= pos + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (end_take) begin
      snap    <= enc;
      snap_ok <= name_ok;
    end else if (out_take) begin
      for (int k = 0; k < NameLen - 1; k++) begin
        snap[k] <= snap[k + 1];
      end
      snap[NameLen - 1] <= PadByte;
    end
  end

  assign byte_rsp.name_byte     = snap[0];
  assign byte_rsp.byte_position = pos;
  assign byte_rsp.name_ok       = snap_ok;
  assign byte_rsp.last_byte     = (pos == LastPos);

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    byte_valid |-> (pos <= LastPos))
    else $error("byte position out of range");

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    end_take |=> (byte_valid && pos == 4'd0))
    else $error("end request did not start a result run");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (done_take && !end_take) |=> !byte_valid)
    else $error("result run did not stop after last byte");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_take && pos != LastPos) |-> !end_take)
    else $error("end request accepted during a result run");

endmodule

### sim/tb_short_name_encoder_core.sv
module tb_short_name_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sne_pkg::*;

  class name_scoreboard;
    logic [7:0]  name_buf [NameLen];
    int unsigned base_n;
    int unsigned ext_n;
    bit          dot;
    bit          err;
    name_byte_t  expected_q [$];
    int          errors;

    // $ % ' - _ @ ~ ` ! ( ) { } ^ # &
    static function logic [7:0] punct(int idx);
      case (idx)
        0:  return 8'h24;
        1:  return 8'h25;
        2:  return 8'h27;
        3:  return 8'h2d;
        4:  return 8'h5f;
        5:  return 8'h40;
        6:  return 8'h7e;
        7:  return 8'h60;
        8:  return 8'h21;
        9:  return 8'h28;
        10: return 8'h29;
        11: return 8'h7b;
        12: return 8'h7d;
        13: return 8'h5e;
        14: return 8'h23;
        default: return 8'h26;
      endcase
    endfunction

    static function bit is_name_char(logic [7:0] c);
      if (c >= ChUpA && c <= ChUpZ) return 1'b1;
      if (c >= Ch0 && c <= Ch9) return 1'b1;
      for (int k = 0; k < 16; k++) begin
        if (c == punct(k)) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void clear_name();
      foreach (name_buf[k]) name_buf[k] = PadByte;
      base_n = 0;
      ext_n  = 0;
      dot    = 1'b0;
      err    = 1'b0;
    endfunction

    function void note_request(char_item_t r);
      logic [7:0] c;
      name_byte_t e;
      bit         ok;
      c = r.character;
      if (r.name_end) begin
        ok = !err && base_n != 0 && (!dot || ext_n != 0);
        for (int k = 0; k < NameLen; k++) begin
          e.name_byte     = name_buf[k];
          e.byte_position = 4'(k);
          e.name_ok       = ok;
          e.last_byte     = (k == NameLen - 1);
          expected_q.push_back(e);
        end
        clear_name();
        return;
      end
      if (err) return;
      if (c == ChDot) begin
        if (dot || base_n == 0) err = 1'b1;
        else dot = 1'b1;
        return;
      end
      if (c >= ChLowA && c <= ChLowZ) c = c - CaseGap;
      if (!is_name_char(c)) begin
        err = 1'b1;
        return;
      end
      if (!dot) begin
        if (base_n >= BaseMax) err = 1'b1;
        else begin
          name_buf[base_n] = c;
          base_n++;
        end
      end else begin
        if (ext_n >= ExtMax) err = 1'b1;
        else begin
          name_buf[BaseMax + ext_n] = c;
          ext_n++;
        end
      end
    endfunction

    function void check_result(name_byte_t got);
      name_byte_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result at position %0d", got.byte_position);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.name_byte !== want.name_byte) begin
        $error("name_byte expected %h got %h", want.name_byte, got.name_byte);
        errors++;
      end
      if (got.byte_position !== want.byte_position) begin
        $error("byte_position expected %0d got %0d", want.byte_position, got.byte_position);
        errors++;
      end
      if (got.name_ok !== want.name_ok) begin
        $error("name_ok expected %b got %b", want.name_ok, got.name_ok);
        errors++;
      end
      if (got.last_byte !== want.last_byte) begin
        $error("last_byte expected %b got %b", want.last_byte, got.last_byte);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_item_t char_req = '0;
  logic       byte_valid;
  logic       byte_ready = 1'b0;
  name_byte_t byte_rsp;

  name_scoreboard sb;
  char_item_t     stim_q [$];

  short_name_encoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_req   (char_req),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_rsp   (byte_rsp)
  );

  always #4 clk = ~clk;

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(0, 3))
      0: return ChUpA + 8'($urandom_range(0, 25));
      1: return ChLowA + 8'($urandom_range(0, 25));
      2: return Ch0 + 8'($urandom_range(0, 9));
      default: return name_scoreboard::punct($urandom_range(0, 15));
    endcase
  endfunction

  task automatic add_char(logic [7:0] c);
    char_item_t item;
    item.character = c;
    item.name_end  = 1'b0;
    stim_q.push_back(item);
  endtask

  task automatic add_end();
    char_item_t item;
    item.character = 8'($urandom_range(0, 255));
    item.name_end  = 1'b1;
    stim_q.push_back(item);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // kinds 0..5 aim to break the name: long base, long extension, leading
  // dot, second dot (if has_dot), bad byte, empty base; others try for a clean name
  task automatic add_name(int kind);
    int         base_len;
    int         ext_len;
    int         start;
    bit         has_dot;
    logic [7:0] bad;
    char_item_t item;
    start    = stim_q.size();
    base_len = $urandom_range(1, 8);
    has_dot  = $urandom_range(0, 1);
    ext_len  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
    case (kind)
      0: base_len = $urandom_range(9, 11);
      1: begin
        has_dot = 1'b1;
        ext_len = $urandom_range(4, 5);
      end
      2: add_char(ChDot);
      5: base_len = 0;
      default: ;
    endcase
    for (int i = 0; i < base_len; i++) begin
      if ($urandom_range(0, 39) == 0) add_char(8'($urandom_range(0, 255)));
      add_char(rand_name_char());
    end
    if (has_dot) add_char(ChDot);
    if (kind == 3) add_char(ChDot);
    if (has_dot || kind == 3) begin
      for (int i = 0; i < ext_len; i++) begin
        if ($urandom_range(0, 39) == 0) add_char(8'($urandom_range(0, 255)));
        add_char(rand_name_char());
      end
    end
    if (kind == 4) begin
      do bad = 8'($urandom_range(0, 255));
      while (name_scoreboard::is_name_char(bad) || bad == ChDot ||
             (bad >= ChLowA && bad <= ChLowZ));
      item.character = bad;
      item.name_end  = 1'b0;
      stim_q.insert($urandom_range(start, stim_q.size()), item);
    end
    add_end();
  endtask

  initial begin
    int calm;
    int gap;
    sb = new;
    sb.clear_name();
    calm = 0;

    add_end();
    add_char(ChDot);
    add_end();
    add_char(8'h00);
    add_end();
    add_text("~AZaz09$&");
    add_end();
    add_text("a.b.");
    add_end();
    add_text("m.");
    add_end();
    add_text("k");
    add_char(8'hff);
    add_text("q");
    add_end();
    add_text("_.");
    add_char(8'h60);
    add_text("{}!");
    add_end();

    while (stim_q.size() < 320) begin
      if ($urandom_range(0, 9) < 7) add_name(6);
      else add_name($urandom_range(0, 5));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_q[i]) begin
      gap = draw_gap(calm);
      if (gap > 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      char_valid <= 1'b1;
      char_req   <= stim_q[i];
      do @(posedge clk);
      while (char_ready !== 1'b1);
      sb.note_request(stim_q[i]);
    end
    char_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int calm;
    int gap;
    calm = 0;
    forever begin
      gap = draw_gap(calm);
      if (gap > 0) begin
        byte_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      byte_ready <= 1'b1;
      do @(posedge clk);
      while (byte_valid !== 1'b1);
      sb.check_result(byte_rsp);
    end
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
